/* sv/ted_pkg.sv */
// shared types and constants for the text encoding detector
`timescale 1ns / 1ps

package ted_pkg;

    // encoding class codes
    typedef enum logic [3:0] {
        ENC_ASCII     = 4'd0,
        ENC_BINARY    = 4'd1,
        ENC_U16LE     = 4'd2,
        ENC_U16LE_BOM = 4'd3,
        ENC_U16BE     = 4'd4,
        ENC_U16BE_BOM = 4'd5,
        ENC_U32LE     = 4'd6,
        ENC_U32BE     = 4'd7,
        ENC_UTF8      = 4'd8,
        ENC_UTF8_BOM  = 4'd9
    } t_enc;

    // configuration register indexes
    localparam logic CFG_BYTE_COUNT  = 1'b0;
    localparam logic CFG_PREFER_UTF8 = 1'b1;

    localparam int CFG_DATA_W = 32;

    // byte order marks as seen in the first bytes, byte k in bits 8k+7..8k
    localparam logic [31:0] BOM_U32LE  = 32'h0000_FEFF;
    localparam logic [31:0] BOM_U32BE  = 32'hFFFE_0000;
    localparam logic [15:0] BOM_U16LE  = 16'hFEFF;
    localparam logic [15:0] BOM_U16BE  = 16'hFFFE;
    localparam logic [15:0] BOM_UTF8_LO = 16'hBBEF;
    localparam logic [7:0]  BOM_UTF8_HI = 8'hBF;

    // utf-8 lead byte limits
    localparam logic [7:0] UTF8_LEAD2_MAX_BAD = 8'hC1;
    localparam logic [7:0] UTF8_LEAD4_LIMIT   = 8'hF5;

    // null threshold divisor: nulls > floor(count / 50) <=> 50 * nulls > count
    localparam int NULL_WEIGHT = 50;

    // what the verdict stage needs from the last byte of a buffer
    typedef struct packed {
        logic [31:0] head_bytes;
        logic        n_lt2;
        logic        n_lt3;
        logic        n_ge4;
        logic        saw_zero_word;
        logic        verdict_valid;
        t_enc        verdict;
        logic        saw_non_ascii;
        logic        pend_zero;
    } t_final;

endpackage

/* sv/ted_stream.sv */
// per-buffer stream state: head bytes, zero words, null count and utf-8 scan
`timescale 1ns / 1ps

module ted_stream import ted_pkg::*; #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_last,
    input  logic [CFG_DATA_W-1:0] i_byte_count,
    output t_final                o_final
);

    localparam int XW    = COUNT_WIDTH + 6;
    localparam int CMP_W = (XW > CFG_DATA_W) ? XW : CFG_DATA_W;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    logic [COUNT_WIDTH-1:0] r_pos,  n_pos;
    logic [31:0]            r_head, n_head;
    logic                   r_waz,  n_waz;
    logic                   r_szw,  n_szw;
    logic [COUNT_WIDTH-1:0] r_null, n_null;
    logic [XW-1:0]          r_x50,  n_x50;
    logic                   r_sna,  n_sna;
    logic [1:0]             r_pend, n_pend;
    logic                   r_vv,   n_vv;
    t_enc                   r_v,    n_v;

    // head capture, aligned zero words and position
    always_comb begin
        n_head = r_head;
        if (r_pos < COUNT_WIDTH'(4)) begin
            n_head = r_head | ({24'd0, i_data_byte} << {r_pos[1:0], 3'b000});
        end
        n_waz = r_waz & (i_data_byte == 8'd0);
        n_szw = r_szw;
        if (r_pos[1:0] == 2'b11) begin
            if (n_waz) begin
                n_szw = 1'b1;
            end
            n_waz = 1'b1;
        end
        n_pos = (r_pos != CNT_MAX) ? r_pos + COUNT_WIDTH'(1) : r_pos;
    end

    // null count and utf-8 scan, latched on first verdict
    always_comb begin
        n_vv   = r_vv;
        n_v    = r_v;
        n_pend = r_pend;
        n_sna  = r_sna;
        n_null = r_null;
        n_x50  = r_x50;
        if (!r_vv) begin
            if (!i_data_byte[7]) begin
                if (i_data_byte == 8'd0) begin
                    if (r_null != CNT_MAX) begin
                        n_null = r_null + COUNT_WIDTH'(1);
                        n_x50  = r_x50 + XW'(NULL_WEIGHT);
                    end
                    if (CMP_W'(n_x50) > CMP_W'(i_byte_count)) begin
                        n_vv = 1'b1;
                        n_v  = r_pos[0] ? ENC_U16LE : ENC_U16BE;
                    end else begin
                        n_pend = 2'd0;
                    end
                end else if (r_pend != 2'd0) begin
                    n_vv = 1'b1;
                    n_v  = ENC_ASCII;
                end
            end else begin
                n_sna = 1'b1;
                if (!i_data_byte[6]) begin
                    if (r_pend == 2'd0) begin
                        n_vv = 1'b1;
                        n_v  = ENC_ASCII;
                    end else begin
                        n_pend = r_pend - 2'd1;
                    end
                end else if (r_pend != 2'd0) begin
                    n_vv = 1'b1;
                    n_v  = ENC_ASCII;
                end else if (!i_data_byte[5]) begin
                    if (i_data_byte <= UTF8_LEAD2_MAX_BAD) begin
                        n_vv = 1'b1;
                        n_v  = ENC_ASCII;
                    end else begin
                        n_pend = 2'd1;
                    end
                end else if (!i_data_byte[4]) begin
                    n_pend = 2'd2;
                end else if (!i_data_byte[3]) begin
                    if (i_data_byte >= UTF8_LEAD4_LIMIT) begin
                        n_vv = 1'b1;
                        n_v  = ENC_ASCII;
                    end else begin
                        n_pend = 2'd3;
                    end
                end else begin
                    n_vv = 1'b1;
                    n_v  = ENC_ASCII;
                end
            end
        end
    end

    // summary of the buffer as of this byte
    always_comb begin
        o_final.head_bytes    = n_head;
        o_final.n_lt2         = n_pos < COUNT_WIDTH'(2);
        o_final.n_lt3         = n_pos < COUNT_WIDTH'(3);
        o_final.n_ge4         = n_pos >= COUNT_WIDTH'(4);
        o_final.saw_zero_word = n_szw;
        o_final.verdict_valid = n_vv;
        o_final.verdict       = n_v;
        o_final.saw_non_ascii = n_sna;
        o_final.pend_zero     = (n_pend == 2'd0);
    end

    // state registers, cleared after the last byte of a buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_en && i_last)) begin
            r_pos  <= '0;
            r_head <= '0;
            r_waz  <= 1'b1;
            r_szw  <= 1'b0;
            r_null <= '0;
            r_x50  <= '0;
            r_sna  <= 1'b0;
            r_pend <= 2'd0;
            r_vv   <= 1'b0;
            r_v    <= ENC_ASCII;
        end else if (i_en) begin
            r_pos  <= n_pos;
            r_head <= n_head;
            r_waz  <= n_waz;
            r_szw  <= n_szw;
            r_null <= n_null;
            r_x50  <= n_x50;
            r_sna  <= n_sna;
            r_pend <= n_pend;
            r_vv   <= n_vv;
            r_v    <= n_v;
        end
    end

endmodule

/* sv/ted_verdict.sv */
// priority selection of the encoding class at the end of a buffer
`timescale 1ns / 1ps

module ted_verdict import ted_pkg::*; (
    input  t_final i_final,
    input  logic   i_prefer_utf8,
    output t_enc   o_encoding
);

    logic [15:0] w_low16;

    assign w_low16 = i_final.head_bytes[15:0];

    // <2 bytes, binary, boms, <3 bytes, utf-8 bom, then the scan
    always_comb begin
        if (i_final.n_lt2) begin
            o_encoding = ENC_ASCII;
        end else if (i_final.saw_zero_word) begin
            o_encoding = ENC_BINARY;
        end else if (i_final.n_ge4 && i_final.head_bytes == BOM_U32LE) begin
            o_encoding = ENC_U32LE;
        end else if (i_final.n_ge4 && i_final.head_bytes == BOM_U32BE) begin
            o_encoding = ENC_U32BE;
        end else if (w_low16 == BOM_U16LE) begin
            o_encoding = ENC_U16LE_BOM;
        end else if (w_low16 == BOM_U16BE) begin
            o_encoding = ENC_U16BE_BOM;
        end else if (i_final.n_lt3) begin
            o_encoding = ENC_ASCII;
        end else if (w_low16 == BOM_UTF8_LO && i_final.head_bytes[23:16] == BOM_UTF8_HI) begin
            o_encoding = ENC_UTF8_BOM;
        end else if (i_final.verdict_valid) begin
            o_encoding = i_final.verdict;
        end else if (i_final.saw_non_ascii && i_final.pend_zero) begin
            o_encoding = ENC_UTF8;
        end else if (!i_final.saw_non_ascii && i_prefer_utf8) begin
            o_encoding = ENC_UTF8;
        end else begin
            o_encoding = ENC_ASCII;
        end
    end

endmodule

/* sv/text_encoding_detector_unit.sv */
// top level: input register, stream state, verdict and result register
// a result follows the last byte through the input register and the result register
// throughput: one byte per cycle while no last byte waits on a stalled result
// a stalled result holds in the output register; other bytes keep flowing, a last byte waits
// reset: synchronous, active low; clears stream state, byte_count to 1,
// prefer_utf8 to 0
`timescale 1ns / 1ps

module text_encoding_detector_unit import ted_pkg::*; #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_last,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [3:0]            o_encoding,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [CFG_DATA_W-1:0] r_byte_count;
    logic                  r_prefer_utf8;
    logic                  r_in_valid;
    logic [7:0]            r_in_byte;
    logic                  r_in_last;
    logic                  r_out_valid;
    t_enc                  r_out_enc;
    logic                  w_adv;
    logic                  w_en;
    t_final                w_final;
    t_enc                  w_enc;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count  <= CFG_DATA_W'(1);
            r_prefer_utf8 <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BYTE_COUNT:  r_byte_count  <= i_cfg_data;
                CFG_PREFER_UTF8: r_prefer_utf8 <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // result register free or being taken; only a last byte needs it
    assign w_adv   = !r_out_valid || !i_stall;
    assign w_en    = r_in_valid && (w_adv || !r_in_last);
    assign o_stall = r_in_valid && r_in_last && !w_adv;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last;
        end
    end

    ted_stream #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_stream (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_en),
        .i_data_byte  (r_in_byte),
        .i_last       (r_in_last),
        .i_byte_count (r_byte_count),
        .o_final      (w_final)
    );

    ted_verdict u_verdict (
        .i_final       (w_final),
        .i_prefer_utf8 (r_prefer_utf8),
        .o_encoding    (w_enc)
    );

    // result register, loaded on the last byte of a buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_en && r_in_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && r_in_last) begin
            r_out_enc <= w_enc;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_encoding = r_out_enc;

    // stall toward the source only while an item waits in the input register
    a_stall_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_in_valid)
        else $error("input stall without a held item");

    // a processed last byte always yields a result next cycle
    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && r_in_last) |=> o_valid)
        else $error("last byte processed but no result");

    // a non-last byte never produces a result on its own
    a_no_spurious_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && !(w_en && r_in_last)) |=> !o_valid)
        else $error("result without a last byte");

    // result codes stay within the defined classes
    a_enc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_encoding <= ENC_UTF8_BOM))
        else $error("encoding out of range");

endmodule

/* tb/tb_text_encoding_detector_unit.sv */
// testbench for the text encoding detector: table-driven and random buffers vs a predictor
`timescale 1ns / 1ps

module tb_text_encoding_detector_unit;
    import ted_pkg::*;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 12;
    localparam int IDLE_PCT      = 22;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_LIMIT   = 2000;
    localparam int PHASES        = 6;
    localparam int PHASE_BYTES   = 285;
    localparam int TIMEOUT_NS    = 5_000_000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    logic [7:0]            i_data_byte;
    logic                  i_last;
    logic                  o_valid;
    logic                  i_stall;
    logic [3:0]            o_encoding;
    logic                  i_cfg_we;
    logic                  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    text_encoding_detector_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data_byte (i_data_byte),
        .i_last      (i_last),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_encoding  (o_encoding),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // directed buffer: first byte in bits 63:56, typed_in marks a class read off by hand
    typedef struct packed {
        logic [63:0] text;
        logic [3:0]  len;
        logic        typed_in;
        t_enc        want;
    } t_row;

    localparam int N_ROWS = 13;
    localparam t_row DIRECTED_ROWS [N_ROWS] = '{
        '{64'h41000000_00000000, 4'd1, 1'b1, ENC_ASCII},      // one-byte buffer
        '{64'h00000000_00000000, 4'd4, 1'b1, ENC_BINARY},     // aligned zero word
        '{64'hFFFE0000_00000000, 4'd4, 1'b1, ENC_U32LE},
        '{64'h0000FEFF_00000000, 4'd4, 1'b1, ENC_U32BE},
        '{64'hFFFE0000_00000000, 4'd2, 1'b1, ENC_U16LE_BOM},
        '{64'hFEFF0000_00000000, 4'd2, 1'b1, ENC_U16BE_BOM},
        '{64'h41420000_00000000, 4'd2, 1'b1, ENC_ASCII},      // too short for a scan verdict
        '{64'hEFBBBF00_00000000, 4'd3, 1'b1, ENC_UTF8_BOM},
        '{64'hC3A94100_00000000, 4'd3, 1'b0, ENC_ASCII},      // valid two-byte sequence
        '{64'h41C08000_00000000, 4'd3, 1'b0, ENC_ASCII},      // overlong lead
        '{64'hE282ACF5_00000000, 4'd4, 1'b0, ENC_ASCII},      // lead past the four-byte range
        '{64'h41004200_00000000, 4'd5, 1'b0, ENC_ASCII},      // nulls over threshold, partial word
        '{64'h80FF4100_00000000, 4'd3, 1'b0, ENC_ASCII}       // continuation without a lead
    };

    // predictor configuration and stream state
    logic [31:0] cfg_byte_count;
    logic        cfg_prefer_utf8;
    logic [31:0] st_pos;
    logic [31:0] st_head;
    logic [31:0] st_nulls;
    logic        st_word_zero;
    logic        st_zero_word;
    logic        st_non_ascii;
    logic        st_latched;
    logic [1:0]  st_pend;
    t_enc        st_verdict;

    t_enc        pending_classes [$];
    logic [7:0]  text_bytes [$];
    int          mismatch_count;
    int          bytes_sent;
    bit          quiet;

    // clock
    initial i_clk = 1'b0;
    always #(HALF_PERIOD) i_clk = ~i_clk;

    // run limit
    initial begin
        #(TIMEOUT_NS);
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("mismatch at %0t ns: %s", $time, what);
    endtask

    task automatic clear_stream_state();
        st_pos       = '0;
        st_head      = '0;
        st_nulls     = '0;
        st_word_zero = 1'b1;
        st_zero_word = 1'b0;
        st_non_ascii = 1'b0;
        st_latched   = 1'b0;
        st_pend      = 2'd0;
        st_verdict   = ENC_ASCII;
    endtask

    task automatic latch_verdict(input t_enc enc);
        st_latched = 1'b1;
        st_verdict = enc;
    endtask

    // null count and utf-8 sequence rules for one byte
    task automatic scan_byte(input logic [7:0] b, input logic [31:0] pos);
        if (!st_latched) begin
            if (!b[7]) begin
                if (b == 8'h00) begin
                    if (st_nulls != '1) st_nulls = st_nulls + 32'd1;
                    if (st_nulls > cfg_byte_count / 32'(NULL_WEIGHT)) begin
                        latch_verdict(pos[0] ? ENC_U16LE : ENC_U16BE);
                    end else begin
                        st_pend = 2'd0;
                    end
                end else if (st_pend != 2'd0) begin
                    latch_verdict(ENC_ASCII);
                end
            end else begin
                st_non_ascii = 1'b1;
                if (!b[6]) begin
                    if (st_pend == 2'd0) latch_verdict(ENC_ASCII);
                    else st_pend = st_pend - 2'd1;
                end else if (st_pend != 2'd0) begin
                    latch_verdict(ENC_ASCII);
                end else if (!b[5]) begin
                    if (b <= UTF8_LEAD2_MAX_BAD) latch_verdict(ENC_ASCII);
                    else st_pend = 2'd1;
                end else if (!b[4]) begin
                    st_pend = 2'd2;
                end else if (!b[3]) begin
                    if (b >= UTF8_LEAD4_LIMIT) latch_verdict(ENC_ASCII);
                    else st_pend = 2'd3;
                end else begin
                    latch_verdict(ENC_ASCII);
                end
            end
        end
    endtask

    // class of a finished buffer of n bytes
    function automatic t_enc final_class(input logic [31:0] n);
        logic [15:0] low16;
        low16 = st_head[15:0];
        if (n < 2) return ENC_ASCII;
        if (st_zero_word) return ENC_BINARY;
        if (n >= 4 && st_head == BOM_U32LE) return ENC_U32LE;
        if (n >= 4 && st_head == BOM_U32BE) return ENC_U32BE;
        if (low16 == BOM_U16LE) return ENC_U16LE_BOM;
        if (low16 == BOM_U16BE) return ENC_U16BE_BOM;
        if (n < 3) return ENC_ASCII;
        if (low16 == BOM_UTF8_LO && st_head[23:16] == BOM_UTF8_HI) return ENC_UTF8_BOM;
        if (st_latched) return st_verdict;
        if (st_non_ascii && st_pend == 2'd0) return ENC_UTF8;
        if (!st_non_ascii && cfg_prefer_utf8) return ENC_UTF8;
        return ENC_ASCII;
    endfunction

    // advance the predicted stream by one accepted byte
    task automatic detect_step(input logic [7:0] b, input logic lst,
                               output logic has_class, output t_enc enc);
        logic [31:0] pos;
        pos = st_pos;
        if (pos < 4) st_head = st_head | (32'(b) << (8 * pos[1:0]));
        if (b != 8'h00) st_word_zero = 1'b0;
        if (pos[1:0] == 2'd3) begin
            if (st_word_zero) st_zero_word = 1'b1;
            st_word_zero = 1'b1;
        end
        scan_byte(b, pos);
        if (st_pos != '1) st_pos = st_pos + 32'd1;
        has_class = lst;
        enc = ENC_ASCII;
        if (lst) begin
            enc = final_class(st_pos);
            clear_stream_state();
        end
    endtask

    // one item on the byte channel; entered and left at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic lst,
                             input logic typed_in, input t_enc want);
        logic has_class;
        t_enc enc;
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= b;
        i_last      <= lst;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        detect_step(b, lst, has_class, enc);
        if (has_class) pending_classes.push_back(typed_in ? want : enc);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_text_bytes();
        for (int k = 0; k < text_bytes.size(); k++)
            send_byte(text_bytes[k], k == text_bytes.size() - 1, 1'b0, ENC_ASCII);
    endtask

    // both registers, written once the block has gone quiet
    task automatic write_settings(input logic [31:0] count, input logic prefer);
        i_valid <= 1'b0;
        while (pending_classes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_BYTE_COUNT;
        i_cfg_data  <= count;
        @(negedge i_clk);
        i_cfg_index <= CFG_PREFER_UTF8;
        i_cfg_data  <= 32'(prefer);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_byte_count  = count;
        cfg_prefer_utf8 = prefer;
    endtask

    // one text character: printable or control ascii, or a multi-byte lead with its full count of continuation bytes
    task automatic add_text_char(input bit allow_multi);
        int kind;
        int conts;
        kind = allow_multi ? $urandom_range(0, 9) : $urandom_range(0, 6);
        conts = 0;
        if (kind < 6) begin
            text_bytes.push_back(8'($urandom_range(8'h20, 8'h7E)));
        end else if (kind == 6) begin
            text_bytes.push_back(8'($urandom_range(8'h01, 8'h1F)));
        end else if (kind == 7) begin
            text_bytes.push_back(8'($urandom_range(8'hC2, 8'hDF)));
            conts = 1;
        end else if (kind == 8) begin
            text_bytes.push_back(8'($urandom_range(8'hE0, 8'hEF)));
            conts = 2;
        end else begin
            text_bytes.push_back(8'($urandom_range(8'hF0, 8'hF4)));
            conts = 3;
        end
        repeat (conts) text_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
    endtask

    // random buffer, mostly well-formed text of some encoding with random content
    task automatic build_random_buffer();
        int style;
        int len;
        int pick;
        logic [7:0] ch;
        text_bytes.delete();
        style = $urandom_range(0, 99);
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(17, 120) : $urandom_range(1, 16);
        pick = $urandom_range(0, 1);
        if (style < 35) begin
            // utf-8 text, sometimes behind its mark
            if ($urandom_range(0, 3) == 0) begin
                text_bytes.push_back(8'hEF);
                text_bytes.push_back(8'hBB);
                text_bytes.push_back(8'hBF);
            end
            while (text_bytes.size() < len) add_text_char(1'b1);
        end else if (style < 50) begin
            // utf-16 text, little endian when pick is set
            if ($urandom_range(0, 1)) begin
                text_bytes.push_back(pick ? 8'hFF : 8'hFE);
                text_bytes.push_back(pick ? 8'hFE : 8'hFF);
            end
            while (text_bytes.size() < len) begin
                ch = 8'($urandom_range(8'h20, 8'h7E));
                text_bytes.push_back(pick ? ch : 8'h00);
                text_bytes.push_back(pick ? 8'h00 : ch);
            end
        end else if (style < 58) begin
            // utf-32 mark followed by zero-heavy content
            text_bytes.push_back(pick ? 8'hFF : 8'h00);
            text_bytes.push_back(pick ? 8'hFE : 8'h00);
            text_bytes.push_back(pick ? 8'h00 : 8'hFE);
            text_bytes.push_back(pick ? 8'h00 : 8'hFF);
            while (text_bytes.size() < len)
                text_bytes.push_back($urandom_range(0, 2) == 0 ? 8'($urandom) : 8'h00);
        end else if (style < 66) begin
            // binary data: all nulls, or random bytes
            while (text_bytes.size() < len)
                text_bytes.push_back(pick ? 8'h00 : 8'($urandom));
        end else if (style < 80) begin
            // plain ascii text
            while (text_bytes.size() < len) add_text_char(1'b0);
        end else if (style < 90) begin
            // utf-8 text with one byte overwritten, or cut inside a sequence
            while (text_bytes.size() < len) add_text_char(1'b1);
            if (pick) begin
                text_bytes[$urandom_range(0, text_bytes.size() - 1)] = 8'($urandom);
            end else begin
                text_bytes.push_back(8'($urandom_range(8'hE0, 8'hF4)));
                if ($urandom_range(0, 1)) text_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
            end
        end else begin
            // noise
            while (text_bytes.size() < len) text_bytes.push_back(8'($urandom));
        end
    endtask

    // result side stalls
    always @(negedge i_clk) begin
        i_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
    end

    // compare each accepted class with the oldest prediction
    always @(posedge i_clk) begin : check_classes
        t_enc want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_classes.size() == 0) begin
                report_mismatch($sformatf("unexpected class %0d", o_encoding));
            end else begin
                want = pending_classes.pop_front();
                if (o_encoding !== want)
                    report_mismatch($sformatf("encoding %0d, predicted %0d", o_encoding, want));
            end
        end
    end

    // stimulus
    initial begin : stimulus
        int r;
        int k;
        int phase;
        int start_count;
        logic [31:0] count;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_data_byte    = 8'h00;
        i_last         = 1'b0;
        i_stall        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = CFG_BYTE_COUNT;
        i_cfg_data     = '0;
        quiet          = 1'b0;
        mismatch_count = 0;
        bytes_sent     = 0;
        cfg_byte_count  = 32'd1;
        cfg_prefer_utf8 = 1'b0;
        clear_stream_state();

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed buffers at reset settings
        for (r = 0; r < N_ROWS; r++) begin
            for (k = 0; k < DIRECTED_ROWS[r].len; k++)
                send_byte(DIRECTED_ROWS[r].text[63 - 8 * k -: 8], k == DIRECTED_ROWS[r].len - 1,
                          DIRECTED_ROWS[r].typed_in, DIRECTED_ROWS[r].want);
        end

        // random buffers under several settings, one phase without any idling
        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: write_settings(32'd1, 1'b1);
                1: write_settings(32'hFFFF_FFFF, 1'b0);
                2: write_settings(32'd50, 1'b1);
                3: write_settings(32'd200, 1'b0);
                4: write_settings(32'($urandom_range(1, 600)), 1'($urandom_range(0, 1)));
                default: begin
                    count = $urandom;
                    if (count == 0) count = 32'd1;
                    write_settings(count, 1'($urandom_range(0, 1)));
                end
            endcase
            quiet = (phase == 2);
            start_count = bytes_sent;
            while (bytes_sent - start_count < PHASE_BYTES) begin
                build_random_buffer();
                send_text_bytes();
            end
        end
        quiet = 1'b0;

        // drain
        i_valid <= 1'b0;
        for (k = 0; k < DRAIN_LIMIT && pending_classes.size() != 0; k++) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_classes.size() != 0)
            report_mismatch($sformatf("%0d predicted classes never came", pending_classes.size()));
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

/* filelist.f */
sv/ted_pkg.sv
sv/ted_stream.sv
sv/ted_verdict.sv
sv/text_encoding_detector_unit.sv
tb/tb_text_encoding_detector_unit.sv
